### hdl/yaz0_pkg.sv
// Shared types and constants for the Yaz0 stream decompressor.
// No dependencies; used by every module of the block except yaz0_ram.
package yaz0_pkg;

    localparam int HISTORY_DEPTH = 4096;
    localparam int HIST_AW       = 12;
    localparam int HEADER_BYTES  = 16;
    localparam int MAX_RESULTS   = 36;
    localparam logic [11:0] DIST_MASK  = 12'h0FFF;
    localparam logic [3:0]  LEN_NIBBLE = 4'hF;
    localparam logic [7:0]  CODE_TOP   = 8'h80;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_start;
    } item_t;

    typedef struct packed {
        logic [63:0] out_word;
        logic [3:0]  byte_count;
        logic        run_end;
        logic        stream_end;
        logic        bad_reference;
    } result_t;

    typedef enum logic [1:0] {
        CMD_HDR,
        CMD_LIT,
        CMD_COPY
    } cmd_kind_t;

    // one command per input byte that needs work in the back end
    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] value;    // expanded length or literal byte
        logic [8:0]  len;      // copy length
        logic [11:0] dist_m1;  // copy distance minus one
    } cmd_t;

    typedef enum logic [1:0] {
        PH_CODE,
        PH_REF1,
        PH_REF2
    } phase_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_WRITE
    } bk_state_t;

endpackage

### hdl/yaz0_stream_decompressor_core.sv
// Yaz0 stream decompressor, top level. Header, code and token bytes are parsed
// and passed as commands through a two-entry queue to the copy engine. The copy
// engine packs a literal directly. A back-reference is loaded first and then
// copied byte by byte (history RAM read, then write and pack), so a long run keeps
// the engine busy and the input stalls once the queue behind it fills. A result
// that waits for pop also stalls the engine. Results leave through a one-entry
// output register.
module yaz0_stream_decompressor_core
    import yaz0_pkg::*;
#(
    parameter int BYTES_PER_RESULT = 8
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    output logic    full,
    input  item_t   item,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    logic cmd_wr, cmd_rd, cmd_valid;
    cmd_t cmd_in, cmd_out;
    logic take;

    assign take = push && !full;

    yaz0_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (item),
        .cmd_wr (cmd_wr),
        .cmd    (cmd_in)
    );

    yaz0_cmd_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_wr),
        .wr_cmd (cmd_in),
        .full   (full),
        .rd_en  (cmd_rd),
        .rd_cmd (cmd_out),
        .valid  (cmd_valid)
    );

    yaz0_back #(
        .BYTES_PER_RESULT (BYTES_PER_RESULT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_out),
        .cmd_rd    (cmd_rd),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

### hdl/yaz0_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module yaz0_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/yaz0_cmd_fifo.sv
// Two-entry command queue between the parser and the copy engine.
// Depends on yaz0_pkg.
module yaz0_cmd_fifo
    import yaz0_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    output logic full,
    input  logic rd_en,
    output cmd_t rd_cmd,
    output logic valid
);

    cmd_t       slot_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
        begin
            slot_reg[wptr_reg] <= wr_cmd;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if ((wr_en && !full) && !(rd_en && valid))
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!(wr_en && !full) && (rd_en && valid))
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (wr_en && !full)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (rd_en && valid)
            begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_next;
        end
    end

    assign full   = (count_reg == 2'd2);
    assign valid  = (count_reg != 2'd0);
    assign rd_cmd = slot_reg[rptr_reg];

endmodule

### hdl/yaz0_front.sv
// Parser: header, code bytes and token bytes; turns them into header, literal and copy commands.
// Depends on yaz0_pkg.
module yaz0_front
    import yaz0_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  take,
    input  item_t item,
    output logic  cmd_wr,
    output cmd_t  cmd
);

    logic        active_reg, active_next;
    logic [4:0]  hpos_reg, hpos_next;
    logic [31:0] explen_reg, explen_next;
    logic [7:0]  code_reg, code_next;
    logic [3:0]  left_reg, left_next;
    phase_t      phase_reg, phase_next;
    logic [15:0] pend_reg, pend_next;

    logic [4:0]  hpos_cur;
    logic [31:0] explen_cur;
    logic [7:0]  code_cur;
    logic [3:0]  left_cur;
    phase_t      phase_cur;
    logic [15:0] pend_cur;
    logic [15:0] ref_word;
    logic [7:0]  b;

    always_comb
    begin
        b = item.in_byte;
        // a stream start discards all parser state
        if (item.stream_start)
        begin
            hpos_cur   = 5'd0;
            explen_cur = 32'd0;
            code_cur   = 8'd0;
            left_cur   = 4'd0;
            phase_cur  = PH_CODE;
            pend_cur   = 16'd0;
        end
        else
        begin
            hpos_cur   = hpos_reg;
            explen_cur = explen_reg;
            code_cur   = code_reg;
            left_cur   = left_reg;
            phase_cur  = phase_reg;
            pend_cur   = pend_reg;
        end
        ref_word = pend_cur | {8'd0, b};

        active_next = active_reg | (take & item.stream_start);
        hpos_next   = hpos_reg;
        explen_next = explen_reg;
        code_next   = code_reg;
        left_next   = left_reg;
        phase_next  = phase_reg;
        pend_next   = pend_reg;
        cmd_wr      = 1'b0;
        cmd         = '{kind: CMD_LIT, value: 32'd0, len: 9'd0, dist_m1: 12'd0};

        if (take && (active_reg || item.stream_start))
        begin
            hpos_next   = hpos_cur;
            explen_next = explen_cur;
            code_next   = code_cur;
            left_next   = left_cur;
            phase_next  = phase_cur;
            pend_next   = pend_cur;
            if (hpos_cur < 5'(HEADER_BYTES))
            begin
                if (hpos_cur >= 5'd4 && hpos_cur <= 5'd7)
                begin
                    explen_next = {explen_cur[23:0], b};
                end
                hpos_next = hpos_cur + 5'd1;
                if (hpos_cur == 5'(HEADER_BYTES - 1))
                begin
                    cmd_wr    = 1'b1;
                    cmd.kind  = CMD_HDR;
                    cmd.value = explen_next;
                end
            end
            else
            begin
                case (phase_cur)
                    PH_REF1:
                    begin
                        pend_next = ref_word;
                        if (ref_word[15:12] == 4'd0)
                        begin
                            phase_next = PH_REF2;
                        end
                        else
                        begin
                            cmd_wr       = 1'b1;
                            cmd.kind     = CMD_COPY;
                            cmd.len      = 9'(ref_word[15:12]) + 9'd2;
                            cmd.dist_m1  = ref_word[11:0] & DIST_MASK;
                            code_next    = {code_cur[6:0], 1'b0};
                            left_next    = (left_cur != 4'd0) ? left_cur - 4'd1 : 4'd0;
                            phase_next   = PH_CODE;
                        end
                    end
                    PH_REF2:
                    begin
                        cmd_wr      = 1'b1;
                        cmd.kind    = CMD_COPY;
                        cmd.len     = 9'(b) + 9'(LEN_NIBBLE) + 9'd3;
                        cmd.dist_m1 = pend_cur[11:0] & DIST_MASK;
                        code_next   = {code_cur[6:0], 1'b0};
                        left_next   = (left_cur != 4'd0) ? left_cur - 4'd1 : 4'd0;
                        phase_next  = PH_CODE;
                    end
                    default:
                    begin
                        phase_next = PH_CODE;
                        if (left_cur == 4'd0)
                        begin
                            code_next = b;
                            left_next = 4'd8;
                        end
                        else if ((code_cur & CODE_TOP) != 8'd0)
                        begin
                            cmd_wr    = 1'b1;
                            cmd.kind  = CMD_LIT;
                            cmd.value = {24'd0, b};
                            code_next = {code_cur[6:0], 1'b0};
                            left_next = left_cur - 4'd1;
                        end
                        else
                        begin
                            pend_next  = {b, 8'd0};
                            phase_next = PH_REF1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            hpos_reg   <= 5'd0;
            explen_reg <= 32'd0;
            code_reg   <= 8'd0;
            left_reg   <= 4'd0;
            phase_reg  <= PH_CODE;
            pend_reg   <= 16'd0;
        end
        else
        begin
            active_reg <= active_next;
            hpos_reg   <= hpos_next;
            explen_reg <= explen_next;
            code_reg   <= code_next;
            left_reg   <= left_next;
            phase_reg  <= phase_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

### hdl/yaz0_back.sv
// Copy engine: executes commands, keeps the history window, packs result words.
// Depends on yaz0_pkg and yaz0_ram.
module yaz0_back
    import yaz0_pkg::*;
#(
    parameter int BYTES_PER_RESULT = 8
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_rd,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    bk_state_t   state_reg, state_next;
    logic [63:0] acc_reg, acc_next;
    logic [3:0]  accn_reg, accn_next;
    logic        accbad_reg, accbad_next;
    logic [12:0] prod_reg, prod_next;
    logic [31:0] left_reg, left_next;
    logic        done_reg, done_next;
    logic [11:0] hptr_reg, hptr_next;
    logic [8:0]  rem_reg, rem_next;
    logic [12:0] dist_reg, dist_next;
    logic [5:0]  kcnt_reg, kcnt_next;
    logic        bad_reg, bad_next;
    logic        ovalid_reg, ovalid_next;
    result_t     res_reg, res_next;

    logic        out_free;
    logic [7:0]  rdata;
    logic        ram_re;
    logic [11:0] raddr;

    // push datapath inputs
    logic [7:0]  p_byte;
    logic        p_bad;
    logic [8:0]  p_rem;
    logic [5:0]  p_k;
    // push datapath outputs
    logic [63:0] p_acc;
    logic [3:0]  p_n;
    logic        p_badacc;
    logic        p_done;
    logic        p_emit;
    logic        p_keep;
    logic        p_run_end;
    logic        p_stall;
    logic        p_commit;

    assign out_free = !ovalid_reg || pop;

    always_comb
    begin
        if (state_reg == BK_WRITE)
        begin
            p_byte = bad_reg ? 8'd0 : rdata;
            p_bad  = bad_reg;
            p_rem  = rem_reg - 9'd1;
            p_k    = kcnt_reg;
        end
        else
        begin
            p_byte = cmd.value[7:0];
            p_bad  = 1'b0;
            p_rem  = 9'd0;
            p_k    = 6'd0;
        end
        p_acc     = acc_reg | (64'(p_byte) << {accn_reg[2:0], 3'b000});
        p_n       = accn_reg + 4'd1;
        p_badacc  = accbad_reg | p_bad;
        p_done    = (left_reg == 32'd1);
        p_emit    = (p_n == 4'(BYTES_PER_RESULT)) || p_done;
        p_keep    = (p_k < 6'(MAX_RESULTS));
        // command's last result: stream end, cap, or no later fill or end in the run
        p_run_end = p_done || (p_k == 6'(MAX_RESULTS - 1)) ||
                    ((p_rem < 9'(BYTES_PER_RESULT)) && ((left_reg - 32'd1) > 32'(p_rem)));
        p_stall   = p_emit && p_keep && !out_free;
    end

    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        accn_next   = accn_reg;
        accbad_next = accbad_reg;
        prod_next   = prod_reg;
        left_next   = left_reg;
        done_next   = done_reg;
        hptr_next   = hptr_reg;
        rem_next    = rem_reg;
        dist_next   = dist_reg;
        kcnt_next   = kcnt_reg;
        bad_next    = bad_reg;
        ovalid_next = ovalid_reg && !pop;
        res_next    = res_reg;
        cmd_rd      = 1'b0;
        ram_re      = 1'b0;
        raddr       = hptr_reg - dist_reg[11:0];
        p_commit    = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        CMD_HDR:
                        begin
                            if (out_free)
                            begin
                                cmd_rd      = 1'b1;
                                acc_next    = 64'd0;
                                accn_next   = 4'd0;
                                accbad_next = 1'b0;
                                prod_next   = 13'd0;
                                left_next   = cmd.value;
                                done_next   = (cmd.value == 32'd0);
                                if (cmd.value == 32'd0)
                                begin
                                    ovalid_next = 1'b1;
                                    res_next    = '{out_word: 64'd0, byte_count: 4'd0,
                                                    run_end: 1'b1, stream_end: 1'b1,
                                                    bad_reference: 1'b0};
                                end
                            end
                        end
                        CMD_LIT:
                        begin
                            if (done_reg)
                            begin
                                cmd_rd = 1'b1;
                            end
                            else if (!p_stall)
                            begin
                                cmd_rd   = 1'b1;
                                p_commit = 1'b1;
                            end
                        end
                        CMD_COPY:
                        begin
                            cmd_rd = 1'b1;
                            if (!done_reg)
                            begin
                                rem_next   = cmd.len;
                                dist_next  = 13'(cmd.dist_m1) + 13'd1;
                                kcnt_next  = 6'd0;
                                state_next = BK_READ;
                            end
                        end
                        default:
                        begin
                            cmd_rd = 1'b1;
                        end
                    endcase
                end
            end
            BK_READ:
            begin
                ram_re     = 1'b1;
                bad_next   = (prod_reg < dist_reg);
                state_next = BK_WRITE;
            end
            BK_WRITE:
            begin
                if (!p_stall)
                begin
                    p_commit = 1'b1;
                    rem_next = rem_reg - 9'd1;
                    if (p_emit && p_keep)
                    begin
                        kcnt_next = kcnt_reg + 6'd1;
                    end
                    state_next = (rem_reg == 9'd1 || p_done) ? BK_IDLE : BK_READ;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        if (p_commit)
        begin
            hptr_next = hptr_reg + 12'd1;
            prod_next = (prod_reg == 13'(HISTORY_DEPTH)) ? prod_reg : prod_reg + 13'd1;
            left_next = left_reg - 32'd1;
            if (p_done)
            begin
                done_next = 1'b1;
            end
            if (p_emit)
            begin
                acc_next    = 64'd0;
                accn_next   = 4'd0;
                accbad_next = 1'b0;
                if (p_keep)
                begin
                    ovalid_next = 1'b1;
                    res_next    = '{out_word: p_acc, byte_count: p_n, run_end: p_run_end,
                                    stream_end: p_done, bad_reference: p_badacc};
                end
            end
            else
            begin
                acc_next    = p_acc;
                accn_next   = p_n;
                accbad_next = p_badacc;
            end
        end
    end

    yaz0_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (p_commit),
        .waddr (hptr_reg),
        .wdata (p_byte),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        dist_reg <= dist_next;
        bad_reg  <= bad_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            accn_reg   <= 4'd0;
            accbad_reg <= 1'b0;
            prod_reg   <= 13'd0;
            left_reg   <= 32'd0;
            done_reg   <= 1'b1;
            hptr_reg   <= 12'd0;
            kcnt_reg   <= 6'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            accn_reg   <= accn_next;
            accbad_reg <= accbad_next;
            prod_reg   <= prod_next;
            left_reg   <= left_next;
            done_reg   <= done_next;
            hptr_reg   <= hptr_next;
            kcnt_reg   <= kcnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign empty  = !ovalid_reg;
    assign result = res_reg;

    a_read_then_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_READ |=> state_reg == BK_WRITE)
        else $error("history read not followed by write");

    a_end_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
        (p_commit && p_done) |=> done_reg)
        else $error("stream end did not mark stream done");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !pop) |=> $stable(res_reg))
        else $error("pending result overwritten");

    a_partial_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && res_reg.byte_count != 4'(BYTES_PER_RESULT)) |-> res_reg.stream_end)
        else $error("short result without stream end");

endmodule

### test/tb.sv
// Testbench for yaz0_stream_decompressor_core: random and directed Yaz0 streams,
// with a behavioral decoder that predicts every output word. Depends on yaz0_pkg.
`timescale 1ns / 100ps

module tb;
    import yaz0_pkg::*;

    localparam int LIMIT_CYCLES = 1500000;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    push = 1'b0;
    logic    pop = 1'b0;
    logic    full;
    logic    empty;
    item_t   item = '0;
    result_t result;

    yaz0_stream_decompressor_core dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .empty(empty), .pop(pop), .result(result)
    );

    always #6 clk = ~clk;

    // decoder state
    logic [7:0]  hist [HISTORY_DEPTH];
    logic [11:0] hptr;
    logic [31:0] produced, exp_len;
    int          hdr_pos;
    logic [7:0]  code;
    int          code_left;
    phase_t      phase;
    logic [15:0] pend_ref;
    logic [63:0] acc_word;
    int          acc_n;
    logic        acc_bad;
    logic        done;

    item_t   pending_items [$];
    result_t expected_words [$];
    int      errors = 0;
    int      step_count;
    bit      feed_done = 0;
    bit      hold_long = 0;

    function automatic void emit_word(bit last);
        result_t r;
        if (step_count < MAX_RESULTS)
        begin
            r.out_word = acc_word;
            r.byte_count = acc_n[3:0];
            r.run_end = 1'b0;
            r.stream_end = last;
            r.bad_reference = acc_bad;
            expected_words.push_back(r);
            step_count++;
        end
        acc_word = '0;
        acc_n = 0;
        acc_bad = 1'b0;
    endfunction

    function automatic void put_byte(logic [7:0] b, logic bad);
        bit last;
        hist[hptr] = b;
        hptr++;
        acc_word |= 64'(b) << (8 * (acc_n % 8));
        acc_n++;
        if (bad) acc_bad = 1'b1;
        produced++;
        last = (produced == exp_len);
        if (acc_n >= 8 || last) emit_word(last);
        if (last) done = 1'b1;
    endfunction

    function automatic void copy_run(int len);
        int span;
        span = int'(pend_ref[11:0]) + 1;
        for (int i = 0; i < len && !done; i++)
        begin
            if (produced < 32'(span)) put_byte(8'h00, 1'b1);
            else put_byte(hist[hptr - 12'(span)], 1'b0);
        end
    endfunction

    function automatic void next_bit();
        code = code << 1;
        if (code_left > 0) code_left--;
        phase = PH_CODE;
    endfunction

    function automatic void decode_byte(item_t it);
        int first;
        first = expected_words.size();
        step_count = 0;
        if (it.stream_start)
        begin
            produced = 0; exp_len = 0; hdr_pos = 0; code = 0; code_left = 0;
            phase = PH_CODE; pend_ref = 0; acc_word = 0; acc_n = 0; acc_bad = 0;
            done = 0;
        end
        if (done) return;
        if (hdr_pos < HEADER_BYTES)
        begin
            if (hdr_pos >= 4 && hdr_pos <= 7) exp_len = {exp_len[23:0], it.in_byte};
            hdr_pos++;
            if (hdr_pos == HEADER_BYTES && exp_len == 0)
            begin
                emit_word(1'b1);
                done = 1'b1;
            end
        end
        else if (phase == PH_REF1)
        begin
            pend_ref = pend_ref | 16'(it.in_byte);
            if (pend_ref[15:12] == 0) phase = PH_REF2;
            else
            begin
                copy_run(int'(pend_ref[15:12]) + 2);
                next_bit();
            end
        end
        else if (phase == PH_REF2)
        begin
            copy_run(int'(it.in_byte) + 18);
            next_bit();
        end
        else if (code_left == 0)
        begin
            code = it.in_byte;
            code_left = 8;
        end
        else if (code & CODE_TOP)
        begin
            put_byte(it.in_byte, 1'b0);
            next_bit();
        end
        else
        begin
            pend_ref = {it.in_byte, 8'h00};
            phase = PH_REF1;
        end
        if (expected_words.size() > first)
            expected_words[expected_words.size() - 1].run_end = 1'b1;
    endfunction

    // stimulus helpers
    function automatic void add(logic [7:0] b, logic s = 1'b0);
        item_t it;
        it.in_byte = b;
        it.stream_start = s;
        pending_items.push_back(it);
    endfunction

    function automatic void add_header(logic [31:0] len);
        add(8'($urandom_range(0, 255)), 1'b1);
        for (int i = 1; i < 16; i++)
            add((i >= 4 && i <= 7) ? len[8 * (7 - i) +: 8] : 8'($urandom));
    endfunction

    // well-formed stream of random tokens; may overrun or end early
    function automatic void add_stream(int len, int ntok);
        logic [7:0] c;
        add_header(32'(len));
        for (int t = 0; t < ntok; t++)
        begin
            if (t % 8 == 0)
            begin
                c = 8'($urandom);
                add(c);
            end
            if (c[7 - t % 8]) add(8'($urandom));
            else
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    add({4'h0, 4'($urandom)});
                    add(8'($urandom));
                    add($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 20)));
                end
                else
                begin
                    add({4'($urandom_range(1, 15)), 4'($urandom_range(0, 1) ? 0 : $urandom)});
                    add($urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom));
                end
            end
        end
    endfunction

    // driver
    int   send_gap = 0;
    logic accepted_flag = 1'b0;
    bit   offering = 0;

    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            decode_byte(item);
            accepted_flag <= 1'b1;
        end
        else
            accepted_flag <= 1'b0;
    end

    always @(negedge clk)
    begin
        int gap;
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else if (offering && !accepted_flag)
        begin
            // still waiting on the handshake
        end
        else if (send_gap > 0)
        begin
            send_gap <= send_gap - 1;
            push <= 1'b0;
            offering <= 0;
        end
        else if (pending_items.size() > 0)
        begin
            gap = hold_long ? 0 : $urandom_range(0, 4);
            if ($urandom_range(0, 3) == 0) gap = 0;
            item <= pending_items.pop_front();
            push <= 1'b1;
            offering <= 1;
            send_gap <= gap;
        end
        else
        begin
            push <= 1'b0;
            offering <= 0;
            feed_done <= 1;
        end
    end

    // monitor
    int   pop_gap = 0;
    // empty as seen at the last rising edge, so the monitor knows a pop took place
    logic empty_q = 1'b1;
    always @(posedge clk) empty_q <= empty;

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word %h", result);
                errors++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (result.out_word !== want.out_word)
                begin
                    $error("out_word exp %h got %h", want.out_word, result.out_word);
                    errors++;
                end
                if (result.byte_count !== want.byte_count)
                begin
                    $error("byte_count exp %0d got %0d", want.byte_count, result.byte_count);
                    errors++;
                end
                if (result.run_end !== want.run_end)
                begin
                    $error("run_end exp %0b got %0b", want.run_end, result.run_end);
                    errors++;
                end
                if (result.stream_end !== want.stream_end)
                begin
                    $error("stream_end exp %0b got %0b", want.stream_end, result.stream_end);
                    errors++;
                end
                if (result.bad_reference !== want.bad_reference)
                begin
                    $error("bad_reference exp %0b got %0b",
                           want.bad_reference, result.bad_reference);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        int gap;
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_long)
            pop <= 1'b0;
        else if (pop && !empty_q)
        begin
            gap = $urandom_range(0, 4);
            if ($urandom_range(0, 3) == 0) gap = 0;
            pop_gap <= gap;
            pop <= (gap == 0);
        end
        else if (pop_gap > 0)
        begin
            pop_gap <= pop_gap - 1;
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    initial
    begin
        int cycles;
        for (int i = 0; i < HISTORY_DEPTH; i++) hist[i] = 8'h00;
        hptr = 0; produced = 0; exp_len = 0; hdr_pos = 0; code = 0; code_left = 0;
        phase = PH_CODE; pend_ref = 0; acc_word = 0; acc_n = 0; acc_bad = 0; done = 1;

        // directed: idle bytes, empty stream, literals of extremes, a short copy
        add(8'hFF); add(8'h00);
        add_header(32'd0);
        add_header(32'd12);
        add(8'hE0); add(8'hFF); add(8'h00); add(8'hA5);
        add(8'hF2); add(8'h00);                 // short copy, distance 513, cut at end
        add(8'h0F); add(8'hFF); add(8'hFF);     // past the end, ignored
        add(8'h55);                             // past the end, ignored
        // random streams
        while (pending_items.size() < 230)
        begin
            if ($urandom_range(0, 9) == 0) add(8'($urandom));
            add_stream($urandom_range(0, 9) == 0 ? $urandom_range(0, 3)
                       : ($urandom_range(0, 5) == 0 ? $urandom_range(200, 600)
                          : $urandom_range(4, 60)),
                       $urandom_range(2, 14));
        end
        // random header length MSBs set too, stream cut by a restart
        add_header({8'($urandom), 24'($urandom)});
        add(8'h80); add(8'h11);
        add_stream(40, 6);

        repeat (9) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        cycles = 0;
        fork
            begin
                repeat (200) @(posedge clk);
                hold_long = 1;
                repeat (600) @(posedge clk);
                hold_long = 0;
            end
            begin
                while (!(feed_done && expected_words.size() == 0 && !push))
                begin
                    @(posedge clk);
                    cycles++;
                    if (cycles > LIMIT_CYCLES)
                    begin
                        $display("Regression FAIL");
                        $finish;
                    end
                end
                repeat (1200) @(posedge clk);
                if (errors == 0 && empty)
                    $display("Regression PASS");
                else
                    $display("Regression FAIL");
                $finish;
            end
        join
    end
endmodule

### filelist.f
hdl/yaz0_pkg.sv
hdl/yaz0_ram.sv
hdl/yaz0_cmd_fifo.sv
hdl/yaz0_front.sv
hdl/yaz0_back.sv
hdl/yaz0_stream_decompressor_core.sv
test/tb.sv
